/* rtl/kmp_stream_matcher_assert.svh */
// kmp_stream_matcher_assert.svh: assertion macros for the KMP stream matcher.
// Uses the clock aclk and the active-low reset aresetn of the including module.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define KMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KMP_ASSERT(lbl, prop, msg)
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/kmp_pkg.sv */
// kmp_pkg: constants, operation codes and result type of the KMP stream matcher.
// No dependencies.
package kmp_pkg;

    localparam int unsigned MAX_PATTERN = 64;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned IDX_W       = $clog2(MAX_PATTERN);
    localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned END_W       = 32;
    localparam int unsigned S_DATA_W    = 16;
    localparam int unsigned M_DATA_W    = 48;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2
    } op_t;

    // Result fields, match_found in bit 0
    typedef struct packed {
        logic             overflow;
        logic [LEN_W-1:0] length;
        logic [END_W-1:0] end_pos;
        logic             found;
    } kmp_result_t;

endpackage

/* rtl/kmp_ram.sv */
// kmp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/kmp_stream_matcher.sv */
// Streaming Knuth-Morris-Pratt matcher:
// One transaction in on s_*, one result transaction out on m_* per input item.
// Start or append stores a pattern byte and its failure entry, or flags overflow
// when full; operation text steps the match state and reports full matches.
// Input s_tdata holds operation in [1:0] and character in [9:2].
// Output m_tdata holds match_found [0], match_end [32:1], matched_length [39:33]
// and pattern_overflow [40].
// One item is handled at a time; s_tready is high only while the sequencer idles.
// Start, appends to an empty or full pattern, unused operations and text with no
// pattern finish straight from idle; other items are issued, then load a
// failure entry (appends, and text that must first drop from a full match), then
// compare, walking the failure chain one step at a time through the single
// compare unit and the two RAM read ports.
// A finished result sits in the output register; if the receiver stalls, the
// next item may still be accepted and its result waits in a holding register,
// and the input then stays stalled until the output register drains.
// Reset (aresetn low, synchronous) empties the pattern and clears the match
// state and text position; pattern RAM contents are left as they are.
`include "kmp_stream_matcher_assert.svh"

module kmp_stream_matcher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] operation, [9:2] character
    input  logic [kmp_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] match_found, [32:1] match_end, [39:33] matched_length, [40] pattern_overflow
    output logic [kmp_pkg::M_DATA_W-1:0]  m_tdata
);

    import kmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOADF,
        ST_CMP,
        ST_WAIT
    } state_t;

    state_t             state_reg, state_next;
    logic               text_reg, text_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   t_reg, t_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic [LEN_W-1:0]   cur_reg, cur_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    kmp_result_t        m_res_reg, m_res_next;
    kmp_result_t        pend_reg, pend_next;

    logic               fin;
    kmp_result_t        fin_res;
    logic               out_free;
    op_t                op;
    logic [CHAR_W-1:0]  ch;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   t_fin;
    logic               hit;
    logic [POS_W-1:0]   pos_inc;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [CHAR_W-1:0]  pat_wdata;
    logic [IDX_W-1:0]   pat_raddr;
    logic [IDX_W-1:0]   fail_raddr;
    logic [LEN_W-1:0]   fail_wdata;
    logic [CHAR_W-1:0]  pat_rdata;
    logic [LEN_W-1:0]   fail_rdata;

    // Pattern bytes and failure entries
    kmp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pat_wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    kmp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERN)) u_fail_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_res_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign ch       = s_tdata[OP_W +: CHAR_W];
    assign hit      = (pat_rdata == char_reg);
    assign pos_inc  = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
    assign len      = (op == OP_START) ? '0 : plen_reg;

    // Sequencer: issue RAM reads, walk the failure chain, finish the item
    always_comb begin
        state_next   = state_reg;
        text_next    = text_reg;
        char_next    = char_reg;
        len_next     = len_reg;
        t_next       = t_reg;
        plen_next    = plen_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        pend_next    = pend_reg;
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        fin          = 1'b0;
        fin_res      = '0;
        t_fin        = t_reg;
        ram_we       = 1'b0;
        ram_waddr    = len_reg[IDX_W-1:0];
        pat_wdata    = char_reg;
        fail_wdata   = '0;
        pat_raddr    = '0;
        fail_raddr   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    char_next = ch;
                    case (op) inside
                        OP_START, OP_APPEND: begin
                            // Any pattern byte restarts the text
                            cur_next  = '0;
                            pos_next  = '0;
                            text_next = 1'b0;
                            if (len >= LEN_W'(MAX_PATTERN)) begin
                                fin              = 1'b1;
                                fin_res.overflow = 1'b1;
                            end else if (len == '0) begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                pat_wdata  = ch;
                                fail_wdata = '0;
                                plen_next  = LEN_W'(1);
                                fin        = 1'b1;
                            end else begin
                                len_next   = len;
                                fail_raddr = len[IDX_W-1:0] - IDX_W'(1);
                                state_next = ST_LOADF;
                            end
                        end
                        OP_TEXT: begin
                            text_next = 1'b1;
                            if (plen_reg == '0) begin
                                cur_next        = '0;
                                pos_next        = pos_inc;
                                fin             = 1'b1;
                                fin_res.end_pos = END_W'(pos_reg);
                            end else if (cur_reg >= plen_reg) begin
                                // Full match extended: drop back first
                                fail_raddr = plen_reg[IDX_W-1:0] - IDX_W'(1);
                                state_next = ST_LOADF;
                            end else begin
                                t_next     = cur_reg;
                                pat_raddr  = cur_reg[IDX_W-1:0];
                                fail_raddr = cur_reg[IDX_W-1:0] - IDX_W'(1);
                                state_next = ST_CMP;
                            end
                        end
                        default: begin
                            fin            = 1'b1;
                            fin_res.length = cur_reg;
                        end
                    endcase
                end
            end
            ST_LOADF: begin
                t_next     = fail_rdata;
                pat_raddr  = fail_rdata[IDX_W-1:0];
                fail_raddr = fail_rdata[IDX_W-1:0] - IDX_W'(1);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (t_reg != '0 && !hit) begin
                    // Follow the failure chain one step
                    t_next     = fail_rdata;
                    pat_raddr  = fail_rdata[IDX_W-1:0];
                    fail_raddr = fail_rdata[IDX_W-1:0] - IDX_W'(1);
                end else begin
                    t_fin = hit ? t_reg + LEN_W'(1) : t_reg;
                    fin   = 1'b1;
                    if (text_reg) begin
                        cur_next        = t_fin;
                        pos_next        = pos_inc;
                        fin_res.found   = (t_fin == plen_reg);
                        fin_res.end_pos = END_W'(pos_reg);
                        fin_res.length  = t_fin;
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = len_reg[IDX_W-1:0];
                        fail_wdata = t_fin;
                        plen_next  = len_reg + LEN_W'(1);
                    end
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    m_res_next   = pend_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Deliver the result, or hold it while the output is stalled
        if (fin) begin
            if (out_free) begin
                m_res_next   = fin_res;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                pend_next  = fin_res;
                state_next = ST_WAIT;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            plen_reg    <= '0;
            cur_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            cur_reg     <= cur_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
        text_reg  <= text_next;
        char_reg  <= char_next;
        len_reg   <= len_next;
        t_reg     <= t_next;
        pend_reg  <= pend_next;
        m_res_reg <= m_res_next;
    end

    `KMP_ASSERT(a_match_le_len, cur_reg <= plen_reg, "match length exceeds pattern length")
    `KMP_ASSERT(a_len_le_max, plen_reg <= LEN_W'(MAX_PATTERN), "pattern length over capacity")
    `KMP_ASSERT(a_walk_in_pattern, (state_reg != ST_CMP) || (t_reg < plen_reg), "walk outside pattern")
    `KMP_ASSERT(a_wait_needs_stall, (state_reg != ST_WAIT) || m_valid_reg, "holding with empty output")
    `KMP_ASSERT_NEXT(a_result_kept, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule
